### design/assert_macros.svh
// Assertion macros used by the checker file.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent in the next cycle, masked while in reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent in the same cycle, masked while in reset.
`define AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after reset is seen low.
`define AST_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

### design/wcsr_pkg.sv
// Package for the wall column span rasterizer: widths, codes, stage types.
// No dependencies.
package wcsr_pkg;

  localparam int SCREEN_W_DEF = 160;
  localparam int SCREEN_H_DEF = 120;
  localparam int SECTORS_DEF  = 4;

  localparam int COL_W   = 8;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 4;
  localparam int SEC_W   = 2;
  localparam int MODE_W  = 3;
  localparam int Y_W     = 7;

  localparam int NUM_W = 36;
  localparam int DEN_W = 18;
  localparam int QUO_W = 17;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = MODE_W;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE       = 3'd0,
    MODE_REC_BOT    = 3'd1,
    MODE_REC_TOP    = 3'd2,
    MODE_FILL_FLOOR = 3'd3,
    MODE_FILL_CEIL  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] wcol;
    logic [COLOR_W-1:0] fcol;
    logic [COLOR_W-1:0] ccol;
    logic [MODE_W-1:0]  mode;
    logic               sec_ok;
  } meta_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

### design/wcsr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; widths come from parameters.
module wcsr_div #(
  parameter int NW = 36,
  parameter int DW = 18,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [NW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [NW-1:0]    rem_in;
    logic [DW-1:0]    den_in;
    logic [QB-1:0]    quo_in;
    logic [NW+DW-1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = {{NW{1'b0}}, den_in} << (QB - 1 - s);
    assign ge    = {{DW{1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? NW'({{DW{1'b0}}, rem_in} - trial) : rem_in;
        den_r[s] <= den_in;
        quo_r[s] <= quo_in | (QB'(ge) << (QB - 1 - s));
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

### design/wcsr_store.sv
// Per-sector column store: one write port, one registered read port.
// Clears itself after reset, one entry a cycle. Uses wcsr_pkg.
module wcsr_store #(
  parameter int DEPTH = 640,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wcsr_pkg::store_ctl_t     ctl,
  input  logic [AW-1:0]            addr,
  input  logic [wcsr_pkg::Y_W-1:0] wr_data,
  output logic [wcsr_pkg::Y_W-1:0] rd_data,
  output logic                     busy
);
  import wcsr_pkg::*;

  logic [Y_W-1:0] mem [DEPTH];
  logic [AW-1:0]  clr_r;
  logic           busy_r;
  logic [Y_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == AW'(DEPTH - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) rd_r <= mem[addr];
  end

  assign rd_data = rd_r;
  assign busy    = busy_r;

endmodule

### design/wall_column_span_rasterizer.sv
// Channel  | Dir | tdata                         | tuser
// in_      | in  | column..ceiling_color, 120 b  | surface_mode
// out_     | out | out_column..wall_span_color   | -
// One column per cycle when not stalled or clearing; stages a, b, c, the one-bit-per-stage
// divider lanes for the bottom and top edges, stage m and the output register.
// After reset the column store clears its SECTORS*SCREEN_W (640) entries with in_tready low.
// A stalled result holds the pipeline only when stage m also has a result.
// Top level; uses wcsr_pkg, wcsr_div and wcsr_store.
module wall_column_span_rasterizer #(
  parameter int SCREEN_W = wcsr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = wcsr_pkg::SCREEN_H_DEF,
  parameter int SECTORS  = wcsr_pkg::SECTORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // column, x_left, x_right, bottom_left, bottom_right, top_left, top_right,
  // wall_color, sector, floor_color, ceiling_color, zero pad
  input  logic [wcsr_pkg::IN_DATA_W-1:0]  in_tdata,
  // surface_mode
  input  logic [wcsr_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_column, surface_start, surface_end, surface_color, wall_start,
  // wall_end, wall_span_color, zero pad
  output logic [wcsr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wcsr_pkg::*;

  localparam int DEPTH = SECTORS * SCREEN_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [17:0] W_M1 = 18'(SCREEN_W - 1);
  localparam logic signed [17:0] H_M1 = 18'(SCREEN_H - 1);
  localparam logic signed [17:0] ONE  = 18'sd1;

  logic adv, busy;

  // stage a: accepted request
  logic va_r;
  logic [COL_W-1:0] col_a_r;
  logic signed [COORD_W-1:0] xl_a_r, xr_a_r, bl_a_r, br_a_r, tl_a_r, tr_a_r;
  logic [COLOR_W-1:0] wcol_a_r, fcol_a_r, ccol_a_r;
  logic [SEC_W-1:0] sec_a_r;
  logic [MODE_W-1:0] mode_a_r;

  assign in_tready = adv && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_a_r  <= in_tdata[7:0];
      xl_a_r   <= in_tdata[23:8];
      xr_a_r   <= in_tdata[39:24];
      bl_a_r   <= in_tdata[55:40];
      br_a_r   <= in_tdata[71:56];
      tl_a_r   <= in_tdata[87:72];
      tr_a_r   <= in_tdata[103:88];
      wcol_a_r <= in_tdata[107:104];
      sec_a_r  <= in_tdata[109:108];
      fcol_a_r <= in_tdata[113:110];
      ccol_a_r <= in_tdata[117:114];
      mode_a_r <= in_tuser;
    end
  end

  logic signed [17:0] col_s, xl_s, xr_s, lo, hi;
  logic signed [16:0] dx, dxe, k, db, dt;
  logic signed [18:0] tk;
  logic in_range;
  meta_t meta_a;

  always_comb begin
    col_s = {10'b0, col_a_r};
    xl_s  = {{2{xl_a_r[15]}}, xl_a_r};
    xr_s  = {{2{xr_a_r[15]}}, xr_a_r};
    lo = (xl_s < ONE) ? ONE : ((xl_s > W_M1) ? W_M1 : xl_s);
    hi = (xr_s < ONE) ? ONE : ((xr_s > W_M1) ? W_M1 : xr_s);
    in_range = (col_s >= lo) && (col_s < hi);
    dx  = 17'(xr_s - xl_s);
    dxe = (dx == '0) ? 17'sd1 : dx;
    k   = 17'(col_s - xl_s);
    tk  = (19'(k) <<< 1) + 19'sd1;
    db  = 17'({br_a_r[15], br_a_r} - {bl_a_r[15], bl_a_r});
    dt  = 17'({tr_a_r[15], tr_a_r} - {tl_a_r[15], tl_a_r});
    meta_a.col    = col_a_r;
    meta_a.wcol   = wcol_a_r;
    meta_a.fcol   = fcol_a_r;
    meta_a.ccol   = ccol_a_r;
    meta_a.mode   = mode_a_r;
    meta_a.sec_ok = 32'(sec_a_r) < SECTORS;
  end

  // stage b: products
  logic vb_r;
  meta_t mb_r;
  logic [AW-1:0] ab_r;
  logic signed [16:0] dxe_b_r;
  logic signed [32:0] pbl_r, ptl_r;
  logic signed [35:0] pbd_r, ptd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r && in_range;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mb_r    <= meta_a;
      ab_r    <= AW'(32'(sec_a_r) * SCREEN_W + 32'(col_a_r));
      dxe_b_r <= dxe;
      pbl_r   <= 33'(bl_a_r) * 33'(dxe);
      ptl_r   <= 33'(tl_a_r) * 33'(dxe);
      pbd_r   <= 36'(db) * 36'(tk);
      ptd_r   <= 36'(dt) * 36'(tk);
    end
  end

  // stage c: numerators as sign and magnitude
  logic vc_r;
  meta_t mc_r;
  logic [AW-1:0] ac_r;
  logic [NUM_W-1:0] nb_mag_r, nt_mag_r;
  logic nb_neg_r, nt_neg_r;
  logic [DEN_W-1:0] den_r;
  logic signed [NUM_W-1:0] nb, nt;

  always_comb begin
    nb = NUM_W'({{2{pbl_r[32]}}, pbl_r, 1'b0}) + pbd_r;
    nt = NUM_W'({{2{ptl_r[32]}}, ptl_r, 1'b0}) + ptd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mc_r     <= mb_r;
      ac_r     <= ab_r;
      nb_neg_r <= nb[NUM_W-1];
      nt_neg_r <= nt[NUM_W-1];
      nb_mag_r <= nb[NUM_W-1] ? NUM_W'(-nb) : NUM_W'(nb);
      nt_mag_r <= nt[NUM_W-1] ? NUM_W'(-nt) : NUM_W'(nt);
      den_r    <= {dxe_b_r, 1'b0};
    end
  end

  // divider lanes
  logic [QUO_W-1:0] qb_mag, qt_mag;

  wcsr_div #(.NW(NUM_W), .DW(DEN_W), .QB(QUO_W)) u_div_bot (
    .clk(clk), .en(adv), .num(nb_mag_r), .den(den_r), .quo(qb_mag)
  );

  wcsr_div #(.NW(NUM_W), .DW(DEN_W), .QB(QUO_W)) u_div_top (
    .clk(clk), .en(adv), .num(nt_mag_r), .den(den_r), .quo(qt_mag)
  );

  logic          vd_r  [QUO_W];
  meta_t         md_r  [QUO_W];
  logic [AW-1:0] ad_r  [QUO_W];
  logic          nbd_r [QUO_W];
  logic          ntd_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) vd_r[i] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= vc_r;
      for (int i = 1; i < QUO_W; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      md_r[0]  <= mc_r;
      ad_r[0]  <= ac_r;
      nbd_r[0] <= nb_neg_r;
      ntd_r[0] <= nt_neg_r;
      for (int i = 1; i < QUO_W; i++) begin
        md_r[i]  <= md_r[i-1];
        ad_r[i]  <= ad_r[i-1];
        nbd_r[i] <= nbd_r[i-1];
        ntd_r[i] <= ntd_r[i-1];
      end
    end
  end

  // clamp and column store access
  logic signed [17:0] qb_s, qt_s, yb_c, yt_c;
  logic [Y_W-1:0] yb7, yt7, rd_data;
  meta_t md_l;
  logic vd_l, is_rec;
  store_ctl_t st_ctl;

  always_comb begin
    md_l = md_r[QUO_W-1];
    vd_l = vd_r[QUO_W-1];
    qb_s = nbd_r[QUO_W-1] ? -18'({1'b0, qb_mag}) : 18'({1'b0, qb_mag});
    qt_s = ntd_r[QUO_W-1] ? -18'({1'b0, qt_mag}) : 18'({1'b0, qt_mag});
    yb_c = (qb_s < ONE) ? ONE : ((qb_s > H_M1) ? H_M1 : qb_s);
    yt_c = (qt_s < ONE) ? ONE : ((qt_s > H_M1) ? H_M1 : qt_s);
    yb7  = yb_c[Y_W-1:0];
    yt7  = yt_c[Y_W-1:0];
    is_rec = (md_l.mode == MODE_REC_BOT) || (md_l.mode == MODE_REC_TOP);
    st_ctl.wr_en = adv && vd_l && is_rec && md_l.sec_ok;
    st_ctl.rd_en = adv && vd_l && !is_rec;
  end

  wcsr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .rst_n(rst_n), .ctl(st_ctl), .addr(ad_r[QUO_W-1]),
    .wr_data((md_l.mode == MODE_REC_BOT) ? yb7 : yt7),
    .rd_data(rd_data), .busy(busy)
  );

  // stage m: store data arrives
  logic vm_r;
  meta_t mm_r;
  logic [Y_W-1:0] ybm_r, ytm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (adv) vm_r <= vd_l && !is_rec;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mm_r  <= md_l;
      ybm_r <= yb7;
      ytm_r <= yt7;
    end
  end

  logic [Y_W-1:0] stored, ss, se;
  logic [COLOR_W-1:0] sc;

  always_comb begin
    stored = mm_r.sec_ok ? rd_data : '0;
    ss = '0;
    se = '0;
    sc = '0;
    case (mm_r.mode)
      MODE_FILL_FLOOR: begin
        ss = stored;
        se = ybm_r;
        sc = mm_r.fcol;
      end
      MODE_FILL_CEIL: begin
        ss = ytm_r;
        se = stored;
        sc = mm_r.ccol;
      end
      default: begin
        ss = '0;
      end
    endcase
  end

  // output register
  logic out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign adv = !(out_valid_r && !out_tready && vm_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && vm_r) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv && vm_r) out_data_r <= {4'b0, mm_r.wcol, ytm_r, ybm_r, sc, se, ss, mm_r.col};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### design/wcsr_checker.sv
// Port-level checker for the wall column span rasterizer, bound to the top.
// Uses assert_macros.svh and wcsr_pkg.
`include "assert_macros.svh"

module wcsr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wcsr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wcsr_pkg::*;

  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")
  `AST_RST(a_rst_out, !out_tvalid, "result valid after reset")
  `AST_RST(a_rst_clear, !in_tready, "request taken during store clear")
  `AST_NOW(a_pad_zero, out_tvalid, out_tdata[OUT_DATA_W-1:44] == '0, "result pad bits set")

endmodule

bind wall_column_span_rasterizer wcsr_checker u_wcsr_checker (.*);

### sim/tb_wall_column_span_rasterizer.sv
// Testbench for wall_column_span_rasterizer: directed table, then random column requests.
// Each result is checked against an in-bench span predictor with its own column store, or typed rows' spans.
// Depends on wcsr_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module tb_wall_column_span_rasterizer;
  import wcsr_pkg::*;

  localparam int W = 160;
  localparam int H = 120;
  localparam int N_RANDOM = 1650;

  typedef struct {
    bit [7:0]         col;
    bit signed [15:0] xl, xr, bl, br, tl, tr;
    bit [3:0]         wc;
    bit [1:0]         sec;
    bit [2:0]         mode;
    bit [3:0]         fc, cc;
  } column_req_t;

  typedef struct {
    bit [7:0] col;
    bit [6:0] ss, se;
    bit [3:0] sc;
    bit [6:0] ws, we;
    bit [3:0] wsc;
  } span_t;

  typedef struct {
    column_req_t req;
    bit          typed;
    bit          has_res;
    span_t       res;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  bit [6:0] height_store [4][W];
  span_t    span_q[$];
  row_t     dir_rows[$];
  int       fails;

  wall_column_span_rasterizer u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("wall_column_span_rasterizer: mismatch");
    $finish;
  end

  function automatic longint edge_row(longint l, longint r, longint k, longint dx);
    longint num, y;
    num = 2 * l * dx + (r - l) * (2 * k + 1);
    y = num / (2 * dx);
    if (y < 1) y = 1;
    if (y > H - 1) y = H - 1;
    return y;
  endfunction

  // Updates the column store; returns 1 when the request yields spans.
  function automatic bit predict_spans(column_req_t r, output span_t s);
    longint dx, lo, hi, ybot, ytop;
    bit [6:0] stored;
    s = '{default: 0};
    dx = longint'(r.xr) - longint'(r.xl);
    if (dx == 0) dx = 1;
    lo = r.xl < 1 ? 1 : (r.xl > W - 1 ? W - 1 : r.xl);
    hi = r.xr < 1 ? 1 : (r.xr > W - 1 ? W - 1 : r.xr);
    if (longint'(r.col) < lo || longint'(r.col) >= hi) return 0;
    ybot = edge_row(r.bl, r.br, longint'(r.col) - r.xl, dx);
    ytop = edge_row(r.tl, r.tr, longint'(r.col) - r.xl, dx);
    if (r.mode == MODE_REC_BOT || r.mode == MODE_REC_TOP) begin
      height_store[r.sec][r.col] = (r.mode == MODE_REC_BOT) ? ybot[6:0] : ytop[6:0];
      return 0;
    end
    stored = height_store[r.sec][r.col];
    if (r.mode == MODE_FILL_FLOOR) begin
      s.ss = stored;
      s.se = ybot[6:0];
      s.sc = r.fc;
    end else if (r.mode == MODE_FILL_CEIL) begin
      s.ss = ytop[6:0];
      s.se = stored;
      s.sc = r.cc;
    end
    s.col = r.col;
    s.ws  = ybot[6:0];
    s.we  = ytop[6:0];
    s.wsc = r.wc;
    return 1;
  endfunction

  function automatic column_req_t mk(int col, int xl, int xr, int bl, int br, int tl, int tr,
                                     int wc, int sec, int mode, int fc, int cc);
    column_req_t r;
    r.col = col; r.xl = xl; r.xr = xr; r.bl = bl; r.br = br; r.tl = tl; r.tr = tr;
    r.wc = wc; r.sec = sec; r.mode = mode; r.fc = fc; r.cc = cc;
    return r;
  endfunction

  function automatic span_t sp(int col, int ss, int se, int sc, int ws, int we, int wsc);
    span_t s;
    s.col = col; s.ss = ss; s.se = se; s.sc = sc; s.ws = ws; s.we = we; s.wsc = wsc;
    return s;
  endfunction

  function automatic void add_row(column_req_t r, bit typed = 0, bit has_res = 0,
                                  span_t s = '{default: 0});
    dir_rows.push_back('{req: r, typed: typed, has_res: has_res, res: s});
  endfunction

  function automatic column_req_t rand_req();
    column_req_t r;
    int c;
    if ($urandom_range(0, 99) < 15) begin
      r.col = $urandom_range(0, W - 1);
      r.xl = $urandom; r.xr = $urandom; r.bl = $urandom; r.br = $urandom;
      r.tl = $urandom; r.tr = $urandom;
      r.mode = $urandom_range(0, 7);
    end else begin
      c = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 20) : $urandom_range(1, W - 2);
      r.col = c;
      r.xl = c - int'($urandom_range(0, 60));
      r.xr = c + int'($urandom_range(1, 60));
      r.bl = int'($urandom_range(0, 420)) - 150;
      r.br = int'($urandom_range(0, 420)) - 150;
      r.tl = int'($urandom_range(0, 420)) - 150;
      r.tr = int'($urandom_range(0, 420)) - 150;
      r.mode = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    end
    r.wc = $urandom; r.sec = $urandom; r.fc = $urandom; r.cc = $urandom;
    return r;
  endfunction

  task automatic send_req(column_req_t r, bit typed, bit has_res, span_t exp_s);
    span_t s;
    bit    got;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b0, r.cc, r.fc, r.sec, r.wc, r.tr, r.tl, r.br, r.bl, r.xr, r.xl, r.col};
    in_tuser  <= r.mode;
    do @(posedge clk); while (!in_tready);
    got = predict_spans(r, s);
    if (typed) begin
      got = has_res;
      s = exp_s;
    end
    if (got) span_q.push_back(s);
  endtask

  // Sender: directed table, then bursts of random length with random gaps
  initial begin
    int burst;
    int gap;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    fails = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_row(mk(0, 0, 160, 10, 10, 50, 50, 1, 0, MODE_NONE, 2, 3), 1, 0);
    add_row(mk(159, 0, 160, 10, 10, 50, 50, 1, 0, MODE_NONE, 2, 3), 1, 0);
    add_row(mk(5, 0, 160, 10, 10, 50, 50, 7, 0, MODE_FILL_FLOOR, 9, 3), 1, 1,
            sp(5, 0, 10, 9, 10, 50, 7));
    add_row(mk(5, 0, 160, -32768, -32768, 32767, 32767, 15, 0, MODE_NONE, 15, 15), 1, 1,
            sp(5, 0, 0, 0, 1, 119, 15));
    add_row(mk(7, 0, 160, 30, 30, 80, 80, 0, 1, MODE_REC_BOT, 0, 0), 1, 0);
    add_row(mk(7, 0, 160, 60, 60, 90, 90, 4, 1, MODE_FILL_FLOOR, 5, 6));
    add_row(mk(8, 0, 160, 10, 10, 90, 90, 0, 2, MODE_REC_TOP, 0, 0));
    add_row(mk(8, 0, 160, 5, 5, 20, 20, 3, 2, MODE_FILL_CEIL, 1, 12));
    add_row(mk(9, 0, 160, 15, 25, 40, 70, 2, 3, 5, 4, 5));
    add_row(mk(9, 0, 160, 15, 25, 40, 70, 2, 3, 6, 4, 5));
    add_row(mk(9, 0, 160, 15, 25, 40, 70, 2, 3, 7, 4, 5));
    add_row(mk(5, 5, 5, 10, 10, 50, 50, 1, 0, MODE_NONE, 0, 0), 1, 0);
    add_row(mk(100, -32768, 32767, -32768, 32767, 32767, -32768, 6, 3, MODE_FILL_FLOOR,
               15, 15));
    add_row(mk(20, 0, 160, 300, 300, -300, -300, 0, 3, MODE_REC_BOT, 0, 0));
    add_row(mk(20, 0, 160, 300, 300, -300, -300, 8, 3, MODE_FILL_FLOOR, 15, 0));
    add_row(mk(21, 0, 160, 0, 0, -300, -300, 0, 3, MODE_REC_TOP, 0, 0));
    add_row(mk(21, 0, 160, 50, 50, 100, 100, 15, 3, MODE_FILL_CEIL, 0, 15));
    add_row(mk(1, -5, 2, -20, 200, 3, 117, 11, 0, MODE_NONE, 0, 0));
    add_row(mk(158, 150, 32767, 119, -119, 0, 255, 12, 1, MODE_NONE, 0, 0));
    add_row(mk(159, 150, 32767, 100, 100, 110, 110, 12, 1, MODE_NONE, 0, 0), 1, 0);

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
        send_req(rand_req(), 0, 0, '{default: 0});
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    for (int t = 0; span_q.size() != 0; t++) begin
      if (t > 20000) begin
        $display("wall_column_span_rasterizer: mismatch");
        $finish;
      end
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (fails == 0 && span_q.size() == 0)
      $display("wall_column_span_rasterizer: match");
    else
      $display("wall_column_span_rasterizer: mismatch");
    $finish;
  end

  // Receiver: changing stall pattern, one long hold-off to back up the pipe
  initial begin
    int cyc;
    int pat;
    out_tready <= 1'b0;
    cyc = 0;
    pat = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) pat = $urandom_range(0, 2);
      if (cyc >= 1500 && cyc < 1900)
        out_tready <= 1'b0;
      else case (pat)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    span_t e;
    span_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.col = out_tdata[7:0];
      a.ss  = out_tdata[14:8];
      a.se  = out_tdata[21:15];
      a.sc  = out_tdata[25:22];
      a.ws  = out_tdata[32:26];
      a.we  = out_tdata[39:33];
      a.wsc = out_tdata[43:40];
      if (span_q.size() == 0) begin
        $error("unexpected span request: out_column %0d", a.col);
        fails++;
      end else begin
        e = span_q.pop_front();
        if (a.col != e.col) begin
          $error("out_column exp %0d got %0d", e.col, a.col); fails++;
        end
        if (a.ss != e.ss) begin
          $error("surface_start exp %0d got %0d", e.ss, a.ss); fails++;
        end
        if (a.se != e.se) begin
          $error("surface_end exp %0d got %0d", e.se, a.se); fails++;
        end
        if (a.sc != e.sc) begin
          $error("surface_color exp %0d got %0d", e.sc, a.sc); fails++;
        end
        if (a.ws != e.ws) begin
          $error("wall_start exp %0d got %0d", e.ws, a.ws); fails++;
        end
        if (a.we != e.we) begin
          $error("wall_end exp %0d got %0d", e.we, a.we); fails++;
        end
        if (a.wsc != e.wsc) begin
          $error("wall_span_color exp %0d got %0d", e.wsc, a.wsc); fails++;
        end
      end
    end
  end

endmodule
